FILE: src/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants for the sorted priority queue
// Entry layout, cell control group, status codes and default depth.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int DEPTH_DEFAULT = 64;
	localparam int DATA_W        = 32;
	localparam int COUNT_OUT_W   = 7;

	typedef enum logic [1:0] {
		ST_ENQ   = 2'd0,
		ST_FULL  = 2'd1,
		ST_DEQ   = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef enum logic {
		CMD_ENQ = 1'b0,
		CMD_DEQ = 1'b1
	} cmd_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic signed [DATA_W-1:0] prio;
	} entry_t;

	typedef struct packed {
		logic enq;
		logic deq;
	} cell_ctrl_t;

endpackage

FILE: src/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted cell row
// Holds one entry; on insert it shifts back, takes the new entry or keeps
// its own; on remove it takes the entry from its right-hand neighbor.
// ----------------------------------------------------------------------------
module spq_cell (
	input  logic                clk,
	input  spq_pkg::cell_ctrl_t ctrl,
	input  spq_pkg::entry_t     in_entry,
	input  spq_pkg::entry_t     left_entry,
	input  spq_pkg::entry_t     right_entry,
	input  logic                left_move,
	input  logic                occupied,
	output spq_pkg::entry_t     entry,
	output logic                move
);

	spq_pkg::entry_t entry_q;

	// empty slots count as larger so the move pattern stays monotonic
	always_comb begin
		move = !occupied || ($signed(entry_q.prio) > $signed(in_entry.prio));
	end

	always_ff @(posedge clk) begin
		if (ctrl.enq) begin
			priority if (left_move) begin
				entry_q <= left_entry;
			end else if (move) begin
				entry_q <= in_entry;
			end else begin
				entry_q <= entry_q;
			end
		end else if (ctrl.deq) begin
			entry_q <= right_entry;
		end
	end

	assign entry = entry_q;

endmodule

FILE: src/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue: bounded priority queue in a row of sorted cells
// Latency: the result beat appears on the cycle after the accepting edge.
// Throughput: one item per cycle; every cell compares and shifts at once.
// busy stays low, so start may be held high on every cycle.
// Reset: clears the entry count and the done strobe; cell contents stay
// undefined, and only slots below the count are ever read.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
	parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                cmd,
	input  logic signed [spq_pkg::DATA_W-1:0]   item_value,
	input  logic signed [spq_pkg::DATA_W-1:0]   item_priority,
	output logic                                done,
	output logic [1:0]                          status,
	output logic signed [spq_pkg::DATA_W-1:0]   head_value,
	output logic signed [spq_pkg::DATA_W-1:0]   head_priority,
	output logic [spq_pkg::COUNT_OUT_W-1:0]     entry_count
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	// occupancy and result beat registers
	logic [CNT_W-1:0]                  count_q;
	logic                              done_q;
	spq_pkg::status_t                  status_q;
	logic signed [spq_pkg::DATA_W-1:0] head_value_q;
	logic signed [spq_pkg::DATA_W-1:0] head_priority_q;

	logic                              accept;
	logic                              full;
	logic                              empty;
	spq_pkg::cell_ctrl_t               ctrl;
	spq_pkg::entry_t                   new_entry;
	spq_pkg::entry_t                   cell_entry [DEPTH];
	logic [DEPTH-1:0]                  cell_move;
	logic [DEPTH-1:0]                  cell_occ;
	logic [CNT_W+spq_pkg::COUNT_OUT_W-1:0] count_ext;

	// the row finishes each item at its accepting edge, so never hold off start
	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign full   = (count_q == CNT_W'(DEPTH));
	assign empty  = (count_q == '0);

	// gate the row: rejected items leave the cells untouched
	always_comb begin
		ctrl.enq = accept && (cmd == spq_pkg::CMD_ENQ) && !full;
		ctrl.deq = accept && (cmd == spq_pkg::CMD_DEQ) && !empty;
	end

	assign new_entry.value = item_value;
	assign new_entry.prio  = item_priority;

	// cell row: slot 0 is the head, higher slots hold larger or equal priorities
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		spq_pkg::entry_t left_e;
		spq_pkg::entry_t right_e;
		logic            left_m;

		assign cell_occ[i] = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_first
			assign left_e = new_entry;
			assign left_m = 1'b0;
		end else begin : g_mid
			assign left_e = cell_entry[i-1];
			assign left_m = cell_move[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			// hold on remove: the tail slot becomes unoccupied anyway
			assign right_e = cell_entry[i];
		end else begin : g_inner
			assign right_e = cell_entry[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.in_entry    (new_entry),
			.left_entry  (left_e),
			.right_entry (right_e),
			.left_move   (left_m),
			.occupied    (cell_occ[i]),
			.entry       (cell_entry[i]),
			.move        (cell_move[i])
		);
	end

	// advance the count and raise the done strobe for one cycle per beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			priority if (ctrl.enq) begin
				count_q <= count_q + CNT_W'(1);
			end else if (ctrl.deq) begin
				count_q <= count_q - CNT_W'(1);
			end else begin
				count_q <= count_q;
			end
		end
	end

	// result payload: head fields only on a successful dequeue, else zero
	always_ff @(posedge clk) begin
		if (accept) begin
			head_value_q    <= '0;
			head_priority_q <= '0;
			if (cmd == spq_pkg::CMD_ENQ) begin
				status_q <= full ? spq_pkg::ST_FULL : spq_pkg::ST_ENQ;
			end else if (empty) begin
				status_q <= spq_pkg::ST_EMPTY;
			end else begin
				status_q        <= spq_pkg::ST_DEQ;
				head_value_q    <= cell_entry[0].value;
				head_priority_q <= cell_entry[0].prio;
			end
		end
	end

	// count is already updated when the beat shows; drop the high bits
	assign count_ext     = {{spq_pkg::COUNT_OUT_W{1'b0}}, count_q};
	assign entry_count   = count_ext[spq_pkg::COUNT_OUT_W-1:0];
	assign done          = done_q;
	assign status        = status_q;
	assign head_value    = head_value_q;
	assign head_priority = head_priority_q;

	// ------------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------------
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	a_beat_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> done)
		else $error("accepted item gave no result beat");

	a_full_reject: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status_q == spq_pkg::ST_FULL) |-> full)
		else $error("full reject while queue not full");

	a_empty_reject: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status_q == spq_pkg::ST_EMPTY) |-> empty)
		else $error("empty reject while queue not empty");

endmodule

FILE: tb/sv/sorted_priority_queue_test.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_test: self-checking bench for the sorted priority queue
// Drives enqueue and dequeue beats with random gaps and keeps a mirror of the
// sorted store. Every result beat is checked field by field against the
// oldest outstanding expectation.
// ----------------------------------------------------------------------------

import spq_pkg::*;

// Mirror of the queue contents plus the list of result beats still owed.
class queue_mirror;

	typedef struct {
		status_t                  status;
		logic signed [DATA_W-1:0] head_value;
		logic signed [DATA_W-1:0] head_priority;
		logic [COUNT_OUT_W-1:0]   entry_count;
	} result_t;

	entry_t  stored[$];
	result_t owed_results[$];
	int      errors;

	function new();
		errors = 0;
	endfunction

	function int owed();
		return owed_results.size();
	endfunction

	// Apply one accepted item to the mirror and queue up the result it causes.
	function void note_item(logic c, logic signed [DATA_W-1:0] v,
			logic signed [DATA_W-1:0] p);
		result_t r;
		entry_t  e;
		int      pos;
		r.head_value    = '0;
		r.head_priority = '0;
		if (c == CMD_ENQ) begin
			if (stored.size() >= DEPTH_DEFAULT) begin
				r.status = ST_FULL;
			end else begin
				// Land after every entry whose priority is less or equal (signed).
				pos = stored.size();
				while (pos > 0 && stored[pos-1].prio > p)
					pos--;
				e.value = v;
				e.prio  = p;
				stored.insert(pos, e);
				r.status = ST_ENQ;
			end
		end else begin
			if (stored.size() == 0) begin
				r.status = ST_EMPTY;
			end else begin
				e = stored.pop_front();
				r.head_value    = e.value;
				r.head_priority = e.prio;
				r.status        = ST_DEQ;
			end
		end
		r.entry_count = COUNT_OUT_W'(stored.size());
		owed_results.push_back(r);
	endfunction

	function void check_result(logic [1:0] st, logic signed [DATA_W-1:0] hv,
			logic signed [DATA_W-1:0] hp, logic [COUNT_OUT_W-1:0] cnt);
		result_t r;
		if (owed_results.size() == 0) begin
			$display("%0t: result beat with nothing owed: status %0d value %0d prio %0d count %0d",
				$time, st, hv, hp, cnt);
			errors++;
			return;
		end
		r = owed_results.pop_front();
		if (st !== r.status) begin
			$display("%0t: status expected %0d got %0d", $time, r.status, st);
			errors++;
		end
		if (hv !== r.head_value) begin
			$display("%0t: head_value expected %0d got %0d", $time, r.head_value, hv);
			errors++;
		end
		if (hp !== r.head_priority) begin
			$display("%0t: head_priority expected %0d got %0d", $time, r.head_priority, hp);
			errors++;
		end
		if (cnt !== r.entry_count) begin
			$display("%0t: entry_count expected %0d got %0d", $time, r.entry_count, cnt);
			errors++;
		end
	endfunction

endclass

module sorted_priority_queue_test;

	localparam int CYCLE_LIMIT = 300000;
	localparam int PHASES      = 12;
	localparam int PHASE_ITEMS = 95;

	logic                        clk;
	logic                        arst_n;
	logic                        start;
	logic                        busy;
	logic                        cmd;
	logic signed [DATA_W-1:0]    item_value;
	logic signed [DATA_W-1:0]    item_priority;
	logic                        done;
	logic [1:0]                  status;
	logic signed [DATA_W-1:0]    head_value;
	logic signed [DATA_W-1:0]    head_priority;
	logic [COUNT_OUT_W-1:0]      entry_count;

	queue_mirror tracker = new();
	int          cycles = 0;

	sorted_priority_queue i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.cmd           (cmd),
		.item_value    (item_value),
		.item_priority (item_priority),
		.done          (done),
		.status        (status),
		.head_value    (head_value),
		.head_priority (head_priority),
		.entry_count   (entry_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case a beat never shows up.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("sorted_priority_queue_test: done, errors");
			$finish;
		end
	end

	// Sample both handshakes at the edge; every input changes by NBA on the
	// same edge, so the values read here are the ones the block sees.
	// Check before noting: a result beat always belongs to an older item.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				tracker.check_result(status, head_value, head_priority, entry_count);
			if (start && !busy)
				tracker.note_item(cmd, item_value, item_priority);
		end
	end

	// Idle length before the next beat: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 9);
		return $urandom_range(10, 40);
	endfunction

	// Priority mix: a narrow band to force ties, the full range, the signed
	// extremes and a band at the top so the signed comparison gets exercised.
	function automatic logic signed [DATA_W-1:0] pick_priority();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return $signed($urandom_range(0, 7)) - 4;
		if (r < 80)
			return $urandom;
		if (r < 90) begin
			case ($urandom_range(0, 3))
				0: return 32'sh8000_0000;
				1: return 32'sh7fff_ffff;
				2: return '0;
				default: return -1;
			endcase
		end
		return 32'sh7fff_fff0 + $urandom_range(0, 31);
	endfunction

	// Present one item and hold it until the accepting edge. start is left
	// high afterward so back-to-back beats never drop it within a step.
	task automatic send_item(input logic c, input logic signed [DATA_W-1:0] v,
			input logic signed [DATA_W-1:0] p, input bit calm);
		int gap;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			// Idle: drop start and toss junk on the payload.
			start         <= 1'b0;
			cmd           <= 1'($urandom_range(0, 1));
			item_value    <= $urandom;
			item_priority <= $urandom;
			repeat (gap) @(posedge clk);
		end
		start         <= 1'b1;
		cmd           <= c;
		item_value    <= v;
		item_priority <= p;
		do
			@(posedge clk);
		while (busy);
	endtask

	// One stretch of random traffic with a given share of enqueues.
	task automatic random_phase(input int n, input int enq_pct, input bit calm);
		logic c;
		for (int i = 0; i < n; i++) begin
			c = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
			send_item(c, $urandom, pick_priority(), calm);
		end
	endtask

	initial begin
		int enq_mix [6];
		enq_mix = '{92, 50, 10, 85, 55, 20};
		start         <= 1'b0;
		cmd           <= CMD_ENQ;
		item_value    <= '0;
		item_priority <= '0;
		arst_n        <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty reject, extremes of value and priority, ties at
		// zero, minus one and the top priority, then drain past empty.
		send_item(CMD_DEQ, 32'sh1234_5678, 32'sh0bad_cafe, 1'b0);
		send_item(CMD_ENQ, 32'sh7fff_ffff, 32'sh7fff_ffff, 1'b0);
		send_item(CMD_ENQ, 32'sh8000_0000, 32'sh8000_0000, 1'b0);
		send_item(CMD_ENQ, 0, 0, 1'b1);
		send_item(CMD_ENQ, -1, -1, 1'b1);
		send_item(CMD_ENQ, 5, 0, 1'b0);
		send_item(CMD_ENQ, 7, -1, 1'b1);
		send_item(CMD_ENQ, 1, 32'sh7fff_ffff, 1'b0);
		for (int i = 0; i < 8; i++)
			send_item(CMD_DEQ, $urandom, $urandom, i[0]);

		// Random: alternate filling, balanced and draining stretches so the
		// queue swings between full and empty; every fourth one runs
		// without gaps.
		for (int ph = 0; ph < PHASES; ph++)
			random_phase(PHASE_ITEMS, enq_mix[ph % 6], (ph % 4) == 1);

		start <= 1'b0;
		while (tracker.owed() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		if (tracker.errors == 0)
			$display("sorted_priority_queue_test: done, clean");
		else
			$display("sorted_priority_queue_test: done, errors");
		$finish;
	end

endmodule
